@@ sv/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define ASSERT_CLK(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, clk_sig, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk_sig, rst_n, !(cond), msg)

`endif

@@ sv/pfra_pkg.sv @@
package pfra_pkg;

	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned TICK_W     = 16;
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned PROD_W     = ACC_W + CFG_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned DIV_CNT_W  = $clog2(ACC_W);

	localparam logic [15:0] CTRL_MSG_LENGTH = 16'd12;
	localparam logic [7:0]  PROBE_REQ_TYPE  = 8'h40;

	localparam logic [CFG_W-1:0] AVG_PERIOD_RST  = 16'd16;
	localparam logic [CFG_W-1:0] DECAY_ALPHA_RST = 16'd1;
	localparam logic [CFG_W-1:0] COUNT_MULT_RST  = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AVG_PERIOD  = 2'd0,
		CFG_DECAY_ALPHA = 2'd1,
		CFG_COUNT_MULT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_DECAY,
		ST_MUL_SCALE,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_decay;
		logic mul_scale;
		logic div_step;
		logic write;
	} pfra_cmd_t;

	typedef struct packed {
		logic div_last;
	} pfra_sts_t;

endpackage

@@ sv/pfra_datapath.sv @@
module pfra_datapath
	import pfra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 mode,
	input  logic [15:0]          frame_length,
	input  logic [7:0]           frame_type_byte,
	input  pfra_cmd_t            cmd,
	output pfra_sts_t            sts,
	output logic [ACC_W-1:0]     average_value,
	output logic [CNT_W-1:0]     pending_probes
);

	logic [CFG_W-1:0]     avg_period_q;
	logic [CFG_W-1:0]     decay_alpha_q;
	logic [CFG_W-1:0]     count_mult_q;
	logic [CNT_W-1:0]     probe_q;
	logic [TICK_W-1:0]    tick_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 is_tick_q;
	logic                 is_probe_q;
	logic [CFG_W-1:0]     period_q;
	logic [PROD_W-1:0]    scaled_q;
	logic [CFG_W-1:0]     rem_q;
	logic [ACC_W-1:0]     dq_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [ACC_W-1:0]     avg_out_q;
	logic [CNT_W-1:0]     pend_out_q;

	logic [TICK_W-1:0]    tick_next;
	logic [CFG_W-1:0]     per_min;
	logic [CFG_W-1:0]     period_next;
	logic [ACC_W-1:0]     mul_x;
	logic [CFG_W-1:0]     mul_y;
	logic [PROD_W-1:0]    mul_p;
	logic [CFG_W:0]       trial;
	logic [CFG_W:0]       diff;
	logic                 ge;
	logic [ACC_W-1:0]     decay;
	logic [PROD_W:0]      sum;
	logic [ACC_W-1:0]     acc_sat;
	logic [CNT_W-1:0]     probe_next;

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_period_q  <= AVG_PERIOD_RST;
			decay_alpha_q <= DECAY_ALPHA_RST;
			count_mult_q  <= COUNT_MULT_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_AVG_PERIOD:  avg_period_q  <= cfg_data;
				CFG_DECAY_ALPHA: decay_alpha_q <= cfg_data;
				CFG_COUNT_MULT:  count_mult_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// period = max(min(avg_period, ticks so far), alpha)
	always_comb begin
		tick_next   = (tick_q == '1) ? tick_q : tick_q + 1'b1;
		per_min     = (avg_period_q < tick_next) ? avg_period_q : tick_next;
		period_next = (per_min < decay_alpha_q) ? decay_alpha_q : per_min;
	end

	// one shared 32x16 multiplier
	always_comb begin
		mul_x = cmd.mul_scale ? probe_q : acc_q;
		mul_y = cmd.mul_scale ? count_mult_q : CFG_W'(period_q - decay_alpha_q);
		mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);
	end

	// restoring divider, one quotient bit per step; high product half is below period
	always_comb begin
		trial = {rem_q, dq_q[ACC_W-1]};
		diff  = trial - {1'b0, period_q};
		ge    = (trial >= {1'b0, period_q});
	end

	always_comb begin
		decay      = (period_q == '0) ? '0 : dq_q;
		sum        = {1'b0, scaled_q} + (PROD_W+1)'(decay);
		acc_sat    = (|sum[PROD_W:ACC_W]) ? '1 : sum[ACC_W-1:0];
		probe_next = (is_probe_q && probe_q != '1) ? probe_q + 1'b1 : probe_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q   <= '0;
			tick_q    <= '0;
			acc_q     <= '0;
			is_tick_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				is_tick_q <= mode;
				if (mode) begin
					tick_q <= tick_next;
				end
			end
			if (cmd.write) begin
				if (is_tick_q) begin
					acc_q   <= acc_sat;
					probe_q <= '0;
				end else begin
					probe_q <= probe_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_probe_q <= (frame_length != CTRL_MSG_LENGTH) && (frame_type_byte == PROBE_REQ_TYPE);
			period_q   <= period_next;
		end
		if (cmd.mul_decay) begin
			rem_q     <= mul_p[PROD_W-1:ACC_W];
			dq_q      <= mul_p[ACC_W-1:0];
			div_cnt_q <= '0;
		end
		if (cmd.mul_scale) begin
			scaled_q <= mul_p;
		end
		if (cmd.div_step) begin
			rem_q     <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
			dq_q      <= {dq_q[ACC_W-2:0], ge};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
		if (cmd.write) begin
			avg_out_q  <= is_tick_q ? acc_sat : acc_q;
			pend_out_q <= is_tick_q ? '0 : probe_next;
		end
	end

	assign sts.div_last   = (div_cnt_q == '1);
	assign average_value  = avg_out_q;
	assign pending_probes = pend_out_q;

endmodule

@@ sv/pfra_ctrl.sv @@
module pfra_ctrl
	import pfra_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      mode,
	input  logic      out_stall,
	input  pfra_sts_t sts,
	output pfra_cmd_t cmd,
	output logic      in_stall,
	output logic      out_valid
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = mode ? ST_MUL_DECAY : ST_WRITE;
				end
			end
			ST_MUL_DECAY: state_next = ST_MUL_SCALE;
			ST_MUL_SCALE: state_next = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_next = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL_DECAY: cmd.mul_decay = 1'b1;
			ST_MUL_SCALE: cmd.mul_scale = 1'b1;
			ST_DIV:       cmd.div_step  = 1'b1;
			ST_WRITE:     cmd.write     = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.write) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/probe_frame_rate_averager.sv @@
// Counts probe-request frames and folds the count into a warm-up exponential average on each
// averaging tick. A frame beat goes from idle straight to the output write. A tick beat passes
// through one multiplier pass for the decay product, one for the count scaling, a restoring
// divider that retires one quotient bit per cycle for the 32 quotient bits, and the output
// write. The controller returns to idle on the same clock edge as the write. One item is in
// flight at a time. A finished result sits in the output register while the next item is
// taken. The write of the following result waits for that register to free up.
// Config registers (index 0 average_period, 1 decay_alpha, 2 count_multiplier) are always ready
// and should be written only while the block is idle; index 3 is ignored.
module probe_frame_rate_averager
	import pfra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [15:0]          frame_length,
	input  logic [7:0]           frame_type_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ACC_W-1:0]     average_value,
	output logic [CNT_W-1:0]     pending_probes
);

	pfra_cmd_t cmd;
	pfra_sts_t sts;

	assign cfg_ready = 1'b1;

	pfra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	pfra_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.frame_length    (frame_length),
		.frame_type_byte (frame_type_byte),
		.cmd             (cmd),
		.sts             (sts),
		.average_value   (average_value),
		.pending_probes  (pending_probes)
	);

endmodule

@@ sv/pfra_checker.sv @@
`include "assert_macros.svh"

module pfra_checker
	import pfra_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_ready,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [ACC_W-1:0] average_value,
	input logic [CNT_W-1:0] pending_probes
);

	logic [ACC_W+CNT_W-1:0] out_beat;

	assign out_beat = {average_value, pending_probes};

	// one item in flight: an accepted beat makes the block busy next cycle
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "taken while busy")

	// a new result only appears at the end of a busy interval
	`ASSERT_CLK(a_result_from_busy, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "stray result")

	// stalled result beat holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_beat), "moved")

	// config port never pushes back
	`ASSERT_NEVER(a_cfg_ready, clk, arst_n, !cfg_ready, "config port not ready")

endmodule

bind probe_frame_rate_averager pfra_checker u_pfra_checker (.*);
